/* hw/rtl/gss_pkg.sv */
// Shared types, constants and register map of the gadget subgaussian sampler.
package gss_pkg;

  // Default values of the top level parameters.
  localparam int MAX_DIGITS_DEF = 64;
  localparam int FRAC_BITS_DEF  = 32;
  localparam int RAND_BITS_DEF  = 24;

  // Fixed field widths.
  localparam int MOD_W     = 64;
  localparam int VAL_W     = 64;
  localparam int BASE_W    = 21;
  localparam int K_W       = 7;
  localparam int DIG_W     = 20;
  localparam int COSET_W   = 42;
  localparam int IP_W      = 42;
  localparam int OUT_W     = 41;
  localparam int OIDX_W    = 6;
  localparam int XLIM_BITS = 40;
  localparam int SUM_W     = 66;

  localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(1) << 20;
  localparam logic [K_W-1:0]    K_MIN    = K_W'(2);

  // Command queue between the front and back parts.
  localparam int QDEPTH = 2;

  // Configuration port.
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 64;
  localparam logic [1:0] REG_MODULUS = 2'd0;
  localparam logic [1:0] REG_BASE    = 2'd1;
  localparam logic [1:0] REG_DIGITS  = 2'd2;

  localparam logic [MOD_W-1:0]  MODULUS_RST = 64'd4294967291;
  localparam logic [BASE_W-1:0] BASE_RST    = 21'd2;
  localparam logic [K_W-1:0]    DIGITS_RST  = 7'd32;

  typedef enum logic {
    CMD_VALUE,
    CMD_FRAC
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [VAL_W-1:0]  data;
  } gss_cmd_t;

  typedef struct packed {
    logic [MOD_W-1:0]  modulus;
    logic [BASE_W-1:0] base;
    logic [K_W-1:0]    num_digits;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VAL_GO,
    ST_DIG_INT,
    ST_DIG_FIX,
    ST_FR_RD,
    ST_FR_DATA,
    ST_FR_DIV,
    ST_FR_MUL,
    ST_FR_FIN,
    ST_OUT_RD,
    ST_OUT_MUL,
    ST_OUT_SUM
  } core_state_t;

endpackage

/* hw/rtl/gss_div.sv */
// Restoring divider that produces one quotient bit per cycle.
module gss_div import gss_pkg::*; #(
  parameter int NUM_W = 64,
  parameter int DIV_W = 21
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [DIV_W-1:0]               rem_init,
  input  logic [NUM_W-1:0]               num,
  input  logic [$clog2(NUM_W+1)-1:0]     steps,
  input  logic [DIV_W-1:0]               divisor,
  output logic [NUM_W-1:0]               quo,
  output logic [DIV_W-1:0]               rem,
  output logic                           done
);

  localparam int SW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_sh;
  logic [DIV_W-1:0] dvs;
  logic [SW-1:0]    cnt;
  logic [DIV_W:0]   trial;
  logic             ge;
  logic [DIV_W-1:0] rem_next;

  // One trial subtraction: the remainder always stays below the divisor.
  always_comb begin
    trial    = {rem, num_sh[NUM_W-1]};
    ge       = trial >= {1'b0, dvs};
    rem_next = ge ? DIV_W'(trial - {1'b0, dvs}) : trial[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem    <= rem_init;
        num_sh <= num;
        dvs    <= divisor;
        quo    <= '0;
        cnt    <= steps;
      end else if (cnt != '0) begin
        rem    <= rem_next;
        num_sh <= num_sh << 1;
        quo    <= {quo[NUM_W-2:0], ge};
        cnt    <= cnt - SW'(1);
        if (cnt == SW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hw/rtl/gss_front.sv */
// Front part: accepts input items, classifies them and queues them as commands.
module gss_front import gss_pkg::*; #(
  parameter int RAND_BITS = RAND_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic                 req_type,
  input  logic [VAL_W-1:0]     value,
  input  logic [RAND_BITS-1:0] rand_fraction,
  output logic                 cmd_valid,
  output gss_cmd_t             cmd,
  input  logic                 cmd_pop
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  gss_cmd_t         q_mem [QDEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  gss_cmd_t         in_cmd;
  logic             do_push;
  logic             do_pop;

  // Classify the incoming transaction.
  always_comb begin
    in_cmd.kind = req_type ? CMD_FRAC : CMD_VALUE;
    in_cmd.data = req_type ? VAL_W'(rand_fraction) : value;
  end

  assign full      = count == CNT_W'(QDEPTH);
  assign cmd_valid = count != '0;
  assign cmd       = q_mem[rptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wptr] <= in_cmd;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= rptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* hw/rtl/gss_core.sv */
// Back part: digit decomposition, randomized rounding per coordinate and digit output.
module gss_core import gss_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int RAND_BITS  = RAND_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     cmd_valid,
  input  gss_cmd_t                 cmd,
  output logic                     cmd_pop,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [OUT_W-1:0]  digit,
  output logic [OIDX_W-1:0]        digit_index,
  output logic                     last
);

  localparam int F     = FRAC_BITS;
  localparam int R     = RAND_BITS;
  localparam int NUM_W = (2 * F > VAL_W) ? 2 * F : VAL_W;
  localparam int DIV_W = (F > BASE_W) ? F : BASE_W;
  localparam int SW    = $clog2(NUM_W + 1);
  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int MC_W  = $clog2(COSET_W + 1);
  localparam int ACC_W = COSET_W + F;
  localparam int Z_W   = IP_W + 2;

  core_state_t state, state_next;

  // Run registers.
  logic [BASE_W-1:0]         run_base;
  logic [CNT_W-1:0]          run_k;
  logic [VAL_W-1:0]          mq;
  logic [VAL_W-1:0]          mu;
  logic [DIG_W-1:0]          dig_q;
  logic [DIG_W-1:0]          dig_u;
  logic [F-1:0]              pd;
  logic [F-1:0]              pt;
  logic [IDX_W-1:0]          idx;
  logic                      pending;
  logic [CNT_W-1:0]          taken;
  logic [R-1:0]              r_reg;
  logic [F-1:0]              t_reg;
  logic [F-1:0]              d_reg;
  logic signed [COSET_W-1:0] xl;
  logic [COSET_W-1:0]        mag;
  logic [ACC_W-1:0]          acc;
  logic [MC_W-1:0]           mcnt;
  logic [IP_W-1:0]           ip_reg;
  logic [F-1:0]              fr_reg;
  logic                      ix_reg;
  logic signed [63:0]        p1;
  logic signed [63:0]        p2;
  logic [DIG_W-1:0]          u_reg;
  logic signed [COSET_W-1:0] cur;
  logic signed [COSET_W-1:0] prev;
  logic                      out_valid;

  // Stores.
  logic [DIG_W-1:0]          modd_mem  [MAX_DIGITS];
  logic [DIG_W-1:0]          vald_mem  [MAX_DIGITS];
  logic [F-1:0]              dvec_mem  [MAX_DIGITS];
  logic [F-1:0]              tvec_mem  [MAX_DIGITS];
  logic [COSET_W-1:0]        coset_mem [MAX_DIGITS];
  logic [DIG_W-1:0]          modd_rd;
  logic [DIG_W-1:0]          vald_rd;
  logic [F-1:0]              d_rd;
  logic [F-1:0]              t_rd;
  logic signed [COSET_W-1:0] coset_rd;

  // Divider lanes.
  logic              start_a, start_b, done_a, done_b;
  logic [DIV_W-1:0]  a_rem_init, b_rem_init, a_div, rem_a, rem_b;
  logic [NUM_W-1:0]  a_num, b_num, quo_a, quo_b;
  logic [SW-1:0]     a_steps;

  // Control strobes and helpers.
  logic              val_we;
  logic              coset_we;
  logic              out_fire;
  logic              is_first;
  logic              k_done;
  logic              at_last;
  logic [CNT_W-1:0]  k_m1;
  logic [BASE_W-1:0] base_cl;
  logic [CNT_W-1:0]  k_cl;
  logic [F-1:0]      ipq;
  logic              ipq_sat;

  // Rounding datapath.
  logic [IP_W-1:0]     ip_use;
  logic [F-1:0]        frac_use;
  logic [F:0]          s_sum;
  logic [F-1:0]        rr;
  logic [F-1:0]        prob;
  logic [Z_W-1:0]      z;
  logic                pick_up;
  logic [COSET_W-1:0]  coset_new;

  // Output datapath.
  logic signed [SUM_W-1:0] vsum;
  logic [OUT_W-1:0]        vsat;

  assign k_m1     = run_k - CNT_W'(1);
  assign is_first = taken == '0;
  assign k_done   = taken == k_m1;
  assign at_last  = idx == k_m1[IDX_W-1:0];
  assign out_fire = !out_valid || pop;

  // Clamp the configuration for a new run.
  always_comb begin
    if (cfg.base < BASE_MIN) begin
      base_cl = BASE_MIN;
    end else if (cfg.base > BASE_MAX) begin
      base_cl = BASE_MAX;
    end else begin
      base_cl = cfg.base;
    end
    if (cfg.num_digits < K_MIN) begin
      k_cl = CNT_W'(K_MIN);
    end else if (cfg.num_digits > K_W'(MAX_DIGITS)) begin
      k_cl = CNT_W'(MAX_DIGITS);
    end else begin
      k_cl = CNT_W'(cfg.num_digits);
    end
  end

  gss_div #(.NUM_W(NUM_W), .DIV_W(DIV_W)) u_div_a (
    .clk(clk), .rst(rst), .start(start_a), .rem_init(a_rem_init), .num(a_num),
    .steps(a_steps), .divisor(a_div), .quo(quo_a), .rem(rem_a), .done(done_a)
  );

  gss_div #(.NUM_W(NUM_W), .DIV_W(DIV_W)) u_div_b (
    .clk(clk), .rst(rst), .start(start_b), .rem_init(b_rem_init), .num(b_num),
    .steps(a_steps), .divisor(a_div), .quo(quo_b), .rem(rem_b), .done(done_b)
  );

  // Integer part of the first coordinate's quotient, with saturation.
  assign ipq     = quo_a[2*F-1:F];
  assign ipq_sat = |(ipq >> XLIM_BITS);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.kind == CMD_VALUE) begin
            state_next = ST_VAL_GO;
          end else if (pending) begin
            state_next = ST_FR_RD;
          end
        end
      end
      ST_VAL_GO:  state_next = ST_DIG_INT;
      ST_DIG_INT: if (done_a) state_next = ST_DIG_FIX;
      ST_DIG_FIX: begin
        if (done_a) begin
          state_next = at_last ? ST_IDLE : ST_DIG_INT;
        end
      end
      ST_FR_RD: state_next = ST_FR_DATA;
      ST_FR_DATA: begin
        if (!is_first) begin
          state_next = ST_FR_MUL;
        end else if (d_rd == '0) begin
          state_next = ST_FR_FIN;
        end else begin
          state_next = ST_FR_DIV;
        end
      end
      ST_FR_DIV: if (done_a) state_next = ST_FR_FIN;
      ST_FR_MUL: if (mcnt == MC_W'(1)) state_next = ST_FR_FIN;
      ST_FR_FIN: state_next = k_done ? ST_OUT_RD : ST_IDLE;
      ST_OUT_RD:  state_next = ST_OUT_MUL;
      ST_OUT_MUL: state_next = ST_OUT_SUM;
      ST_OUT_SUM: begin
        if (out_fire) begin
          state_next = at_last ? ST_IDLE : ST_OUT_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs and divider operands.
  always_comb begin
    cmd_pop    = 1'b0;
    start_a    = 1'b0;
    start_b    = 1'b0;
    val_we     = 1'b0;
    coset_we   = 1'b0;
    a_rem_init = '0;
    b_rem_init = '0;
    a_num      = '0;
    b_num      = '0;
    a_steps    = SW'(VAL_W);
    a_div      = DIV_W'(run_base);
    case (state)
      ST_IDLE: cmd_pop = cmd_valid;
      ST_VAL_GO: begin
        start_a = 1'b1;
        start_b = 1'b1;
        a_num   = NUM_W'(mq) << (NUM_W - VAL_W);
        b_num   = NUM_W'(mu) << (NUM_W - VAL_W);
      end
      ST_DIG_INT: begin
        // The digit just found seeds the fixed-point step of the recurrence.
        if (done_a) begin
          start_a    = 1'b1;
          start_b    = 1'b1;
          a_rem_init = rem_a;
          b_rem_init = rem_b;
          a_num      = NUM_W'(pd) << (NUM_W - F);
          b_num      = NUM_W'(pt) << (NUM_W - F);
          a_steps    = SW'(F);
        end
      end
      ST_DIG_FIX: begin
        if (done_a) begin
          val_we = 1'b1;
          if (!at_last) begin
            start_a = 1'b1;
            start_b = 1'b1;
            a_num   = NUM_W'(mq) << (NUM_W - VAL_W);
            b_num   = NUM_W'(mu) << (NUM_W - VAL_W);
          end
        end
      end
      ST_FR_DATA: begin
        if (is_first && d_rd != '0) begin
          start_a = 1'b1;
          a_num   = NUM_W'({t_rd, {F{1'b0}}}) << (NUM_W - 2 * F);
          a_steps = SW'(2 * F);
          a_div   = DIV_W'(d_rd);
        end
      end
      ST_FR_FIN: coset_we = 1'b1;
      default: ;
    endcase
  end

  // Rounding of one coordinate: floor of the negated center and the upper probability.
  always_comb begin
    ip_use   = is_first ? ip_reg : acc[ACC_W-1:F];
    frac_use = is_first ? fr_reg : acc[F-1:0];
    s_sum    = {1'b0, frac_use} + (is_first ? (F + 1)'(ix_reg) : {1'b0, t_reg});
    rr       = s_sum[F-1:0];
    if (!is_first && xl[COSET_W-1]) begin
      prob = frac_use - t_reg;
      if (frac_use >= t_reg) begin
        z = Z_W'(ip_use);
      end else begin
        z = Z_W'(ip_use) - Z_W'(1);
      end
    end else begin
      prob = (rr == '0) ? '0 : F'(0) - rr;
      z    = Z_W'(0) - Z_W'(ip_use) - Z_W'(s_sum[F]) - Z_W'(rr != '0);
    end
    coset_new = COSET_W'(z + Z_W'(pick_up));
  end

  generate
    if (F >= R) begin : g_cmp_wide_frac
      assign pick_up = (F'(r_reg) << (F - R)) <= prob;
    end else begin : g_cmp_wide_rand
      assign pick_up = r_reg <= (R'(prob) << (R - F));
    end
  endgenerate

  // Output digit: S*x + u, saturated to the result range.
  always_comb begin
    vsum = SUM_W'(p1) + SUM_W'(u_reg);
    if (!at_last) begin
      vsum = vsum + SUM_W'(p2);
    end
    if (idx != '0) begin
      vsum = vsum - SUM_W'(prev);
    end
    if (vsum[SUM_W-1:OUT_W-1] == '0 || vsum[SUM_W-1:OUT_W-1] == '1) begin
      vsat = vsum[OUT_W-1:0];
    end else begin
      vsat = vsum[SUM_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  // Stores: one write and one registered read per cycle, both at idx.
  always_ff @(posedge clk) begin
    if (val_we) begin
      modd_mem[idx] <= dig_q;
      vald_mem[idx] <= dig_u;
      dvec_mem[idx] <= quo_a[F-1:0];
      tvec_mem[idx] <= quo_b[F-1:0];
    end
    if (coset_we) begin
      coset_mem[idx] <= coset_new;
    end
    modd_rd  <= modd_mem[idx];
    vald_rd  <= vald_mem[idx];
    d_rd     <= dvec_mem[idx];
    t_rd     <= tvec_mem[idx];
    coset_rd <= coset_mem[idx];
  end

  // Sequencer registers and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pending   <= 1'b0;
      taken     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            if (cmd.kind == CMD_VALUE) begin
              run_base <= base_cl;
              run_k    <= k_cl;
              mq       <= cfg.modulus;
              mu       <= cmd.data;
              pd       <= '0;
              pt       <= '0;
              idx      <= '0;
              pending  <= 1'b0;
              taken    <= '0;
            end else if (pending) begin
              r_reg <= cmd.data[R-1:0];
              idx   <= is_first ? k_m1[IDX_W-1:0] : IDX_W'(k_m1 - taken);
            end
          end
        end
        ST_DIG_INT: begin
          if (done_a) begin
            mq    <= quo_a[VAL_W-1:0];
            mu    <= quo_b[VAL_W-1:0];
            dig_q <= rem_a[DIG_W-1:0];
            dig_u <= rem_b[DIG_W-1:0];
          end
        end
        ST_DIG_FIX: begin
          if (done_a) begin
            pd <= quo_a[F-1:0];
            pt <= quo_b[F-1:0];
            if (at_last) begin
              pending <= 1'b1;
              taken   <= '0;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        ST_FR_DATA: begin
          t_reg <= t_rd;
          d_reg <= d_rd;
          // A zero divisor saturates the quotient unless the target is zero too.
          if (is_first && d_rd == '0) begin
            ip_reg <= (t_rd == '0) ? '0 : IP_W'(1) << XLIM_BITS;
            fr_reg <= '0;
            ix_reg <= 1'b0;
          end
          mag  <= xl[COSET_W-1] ? COSET_W'(0) - COSET_W'(xl) : COSET_W'(xl);
          acc  <= '0;
          mcnt <= MC_W'(COSET_W);
        end
        ST_FR_DIV: begin
          if (done_a) begin
            ip_reg <= ipq_sat ? IP_W'(1) << XLIM_BITS : IP_W'(ipq);
            fr_reg <= ipq_sat ? '0 : quo_a[F-1:0];
            ix_reg <= !ipq_sat && rem_a != '0;
          end
        end
        ST_FR_MUL: begin
          acc  <= (acc << 1) + (mag[COSET_W-1] ? ACC_W'(d_reg) : '0);
          mag  <= mag << 1;
          mcnt <= mcnt - MC_W'(1);
        end
        ST_FR_FIN: begin
          if (is_first) begin
            xl <= coset_new;
          end
          taken <= taken + CNT_W'(1);
          if (k_done) begin
            idx  <= '0;
            prev <= '0;
          end
        end
        ST_OUT_MUL: begin
          p1    <= 64'($signed({1'b0, modd_rd}) * xl);
          p2    <= 64'($signed({1'b0, run_base}) * coset_rd);
          u_reg <= vald_rd;
          cur   <= coset_rd;
        end
        ST_OUT_SUM: begin
          if (out_fire) begin
            digit       <= vsat;
            digit_index <= OIDX_W'(idx);
            last        <= at_last;
            prev        <= cur;
            if (at_last) begin
              pending <= 1'b0;
              taken   <= '0;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        default: ;
      endcase
      // The output register refills on a sweep step, else it empties when popped.
      if (state == ST_OUT_SUM && out_fire) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty = !out_valid;

endmodule

/* hw/rtl/gadget_subgaussian_sampler_unit.sv */
// Top level of the gadget subgaussian sampler: configuration registers and the two parts.
//
// Usage: the input side is a queue. Each push transaction carries either a value u to
// decompose (req_type 0) or one uniform random fraction (req_type 1). After a value,
// num_digits fractions are needed; the last of them starts num_digits result
// transactions (digit, digit_index, last), which are read from the output queue with pop.
// Fractions that arrive with no value pending are dropped; a new value restarts the run.
// A value is decomposed by the bit-serial divider lanes, which extract one base
// digit and one fixed-point recurrence step at a time. The first fraction takes one
// divider pass; every later fraction a bit-serial multiply over 42 coefficient bits.
// The output sweep handles each digit through the store reads, one multiplier stage
// and the final sum.
// A two-entry command queue lets the input side accept items while the back part works.
// When the receiver holds off pop, the output register holds its digit and the sweep waits.
// Reset (synchronous, active high) empties both queues, drops any pending run and loads
// the register defaults. Configuration is written over the APB-style port at 8*i.
module gadget_subgaussian_sampler_unit import gss_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int RAND_BITS  = RAND_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_AW-1:0]       paddr,
  input  logic [CFG_DW-1:0]       pwdata,
  output logic [CFG_DW-1:0]       prdata,
  output logic                    pready,
  input  logic                    push,
  output logic                    full,
  input  logic                    req_type,
  input  logic [VAL_W-1:0]        value,
  input  logic [RAND_BITS-1:0]    rand_fraction,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [OUT_W-1:0] digit,
  output logic [OIDX_W-1:0]       digit_index,
  output logic                    last
);

  cfg_t       cfg;
  logic [1:0] reg_sel;
  logic       cfg_wr;
  logic       cmd_valid;
  logic       cmd_pop;
  gss_cmd_t   cmd;

  assign pready  = 1'b1;
  assign reg_sel = paddr[CFG_AW-1:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.modulus    <= MODULUS_RST;
      cfg.base       <= BASE_RST;
      cfg.num_digits <= DIGITS_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_MODULUS: cfg.modulus    <= pwdata;
        REG_BASE:    cfg.base       <= pwdata[BASE_W-1:0];
        REG_DIGITS:  cfg.num_digits <= pwdata[K_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (reg_sel)
      REG_MODULUS: prdata = cfg.modulus;
      REG_BASE:    prdata = CFG_DW'(cfg.base);
      REG_DIGITS:  prdata = CFG_DW'(cfg.num_digits);
      default:     prdata = '0;
    endcase
  end

  gss_front #(.RAND_BITS(RAND_BITS)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .req_type(req_type),
    .value(value), .rand_fraction(rand_fraction), .cmd_valid(cmd_valid),
    .cmd(cmd), .cmd_pop(cmd_pop)
  );

  gss_core #(
    .MAX_DIGITS(MAX_DIGITS), .FRAC_BITS(FRAC_BITS), .RAND_BITS(RAND_BITS)
  ) u_core (
    .clk(clk), .rst(rst), .cfg(cfg), .cmd_valid(cmd_valid), .cmd(cmd),
    .cmd_pop(cmd_pop), .empty(empty), .pop(pop), .digit(digit),
    .digit_index(digit_index), .last(last)
  );

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the gadget subgaussian sampler unit.
module tb_top;
  import gss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KMAX = 64;
  localparam int FRB = 32;
  localparam int RNB = 24;
  localparam longint unsigned FX_ONE = 64'd1 << FRB;
  localparam longint unsigned FX_MSK = FX_ONE - 1;
  localparam longint DIG_HI = 64'sd1099511627775;
  localparam longint DIG_LO = -64'sd1099511627776;
  localparam int SETTLE_CYC = 7000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;
  logic push = 1'b0;
  logic full;
  logic req_type = 1'b0;
  logic [VAL_W-1:0] value = '0;
  logic [RNB-1:0] rand_fraction = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [OUT_W-1:0] digit;
  logic [OIDX_W-1:0] digit_index;
  logic last;

  gadget_subgaussian_sampler_unit dut (.*);

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One expected output digit.
  typedef struct {
    logic signed [OUT_W-1:0] dig;
    logic [OIDX_W-1:0]       idx;
    logic                    lst;
  } digit_exp_t;

  digit_exp_t digit_q[$];
  int fail_cnt = 0;
  int items_sent = 0;
  int digits_seen = 0;
  int runs_done = 0;

  // Shadow of the configuration registers and of the sampler state.
  longint unsigned cfg_mod = 64'd4294967291;
  int unsigned cfg_base = 2;
  int unsigned cfg_k = 32;
  int unsigned mod_dig[KMAX];
  int unsigned val_dig[KMAX];
  longint unsigned dvec[KMAX];
  longint unsigned tvec[KMAX];
  longint coset[KMAX];
  bit run_open = 0;
  int unsigned fr_taken = 0;
  int unsigned run_b = 2;
  int unsigned run_k = 2;

  // Bit-serial fixed-point division floor((hi*2^F + lo)/dv).
  function automatic longint unsigned fx_div(longint unsigned hi, longint unsigned lo,
                                             longint unsigned dv, output bit inexact);
    longint unsigned rem, q;
    rem = hi;
    q = 0;
    for (int j = FRB - 1; j >= 0; j--) begin
      rem = (rem << 1) | ((lo >> j) & 64'd1);
      q = q << 1;
      if (rem >= dv) begin
        rem = rem - dv;
        q = q | 64'd1;
      end
    end
    inexact = (rem != 0);
    return q;
  endfunction

  // Floor of -(ip + s/2^F) and the fraction above that floor.
  function automatic void neg_floor(longint unsigned ip, longint unsigned s,
                                    output longint z, output longint unsigned prob);
    longint a;
    longint unsigned r;
    a = longint'(s >> FRB);
    r = s & FX_MSK;
    if (r == 0) begin
      z = -longint'(ip) - a;
      prob = 0;
    end else begin
      z = -longint'(ip) - a - 1;
      prob = FX_ONE - r;
    end
  endfunction

  function automatic bit round_up(longint unsigned r, longint unsigned prob);
    return (r << (FRB - RNB)) <= prob;
  endfunction

  // Advance the shadow state by one accepted transaction and queue its digits.
  task automatic sampler_step(bit kind, longint unsigned u, longint unsigned r,
                              bit use_typed, longint typed_dig);
    longint unsigned mq, mu, pd, pt, t, d, ip, fr, prob, mag;
    logic [127:0] prod;
    longint z, xl, v;
    bit ix;
    int unsigned i;
    digit_exp_t e;
    if (kind == CMD_VALUE) begin
      mq = cfg_mod;
      mu = u;
      pd = 0;
      pt = 0;
      run_b = cfg_base < 2 ? 2 : (cfg_base > (1 << 20) ? (1 << 20) : cfg_base);
      run_k = cfg_k < 2 ? 2 : (cfg_k > KMAX ? KMAX : cfg_k);
      for (int n = 0; n < run_k; n++) begin
        mod_dig[n] = mq % run_b;
        mq = mq / run_b;
        val_dig[n] = mu % run_b;
        mu = mu / run_b;
        pd = fx_div(mod_dig[n], pd, run_b, ix);
        pt = fx_div(val_dig[n], pt, run_b, ix);
        dvec[n] = pd;
        tvec[n] = pt;
      end
      run_open = 1;
      fr_taken = 0;
      return;
    end
    if (!run_open) return;
    if (fr_taken == 0) begin
      // Top coordinate: quotient of target and d, saturated when d is zero.
      t = tvec[run_k-1];
      d = dvec[run_k-1];
      fr = 0;
      ix = 0;
      if (d == 0) begin
        ip = (t == 0) ? 0 : (64'd1 << 40);
      end else begin
        ip = t / d;
        if (ip >= (64'd1 << 40)) ip = 64'd1 << 40;
        else fr = fx_div(t % d, 0, d, ix);
      end
      neg_floor(ip, fr + (ix ? 1 : 0), z, prob);
      coset[run_k-1] = z + (round_up(r, prob) ? 1 : 0);
    end else begin
      // Lower coordinates: target minus the top coefficient times d.
      xl = coset[run_k-1];
      mag = xl < 0 ? -xl : xl;
      i = run_k - 1 - fr_taken;
      t = tvec[i];
      prod = 128'(mag) * 128'(dvec[i]);
      ip = prod[95:32];
      fr = 64'(prod[31:0]);
      if (xl < 0) begin
        if (fr >= t) begin
          z = longint'(ip);
          prob = fr - t;
        end else begin
          z = longint'(ip) - 1;
          prob = fr + FX_ONE - t;
        end
      end else begin
        neg_floor(ip, fr + t, z, prob);
      end
      coset[i] = z + (round_up(r, prob) ? 1 : 0);
    end
    fr_taken++;
    if (fr_taken < run_k) return;
    // All coordinates drawn: emit S*x + u digit by digit.
    xl = coset[run_k-1];
    for (int n = 0; n < run_k; n++) begin
      v = longint'(mod_dig[n]) * xl + longint'(val_dig[n]);
      if (n < run_k - 1) v += longint'(run_b) * coset[n];
      if (n > 0) v -= coset[n-1];
      if (v > DIG_HI) v = DIG_HI;
      if (v < DIG_LO) v = DIG_LO;
      e.dig = use_typed ? typed_dig[OUT_W-1:0] : v[OUT_W-1:0];
      e.idx = n[OIDX_W-1:0];
      e.lst = (n == run_k - 1);
      digit_q.push_back(e);
    end
    runs_done++;
    run_open = 0;
    fr_taken = 0;
  endtask

  // Register write over the configuration port.
  task automatic reg_write(logic [1:0] idx, longint unsigned data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'(idx) << 3;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_MODULUS: cfg_mod = data;
      REG_BASE:    cfg_base = data & 64'h1FFFFF;
      REG_DIGITS:  cfg_k = data & 64'h7F;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(longint unsigned m, longint unsigned b, longint unsigned k);
    reg_write(REG_MODULUS, m);
    reg_write(REG_BASE, b);
    reg_write(REG_DIGITS, k);
  endtask

  // Sender: random gap, then hold push until the transaction is taken.
  int send_fast = 0;
  task automatic send_item(bit kind, longint unsigned u, longint unsigned r,
                           bit use_typed = 0, longint typed_dig = 0);
    int gap;
    if (send_fast > 0) begin
      send_fast--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 15) == 0) send_fast = $urandom_range(10, 40);
    end
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push <= 1'b1;
    req_type <= kind;
    value <= u;
    rand_fraction <= r[RNB-1:0];
    do @(posedge clk); while (full);
    items_sent++;
    sampler_step(kind, u, r, use_typed, typed_dig);
  endtask

  // Drain: all digits back, then let any run with no output finish.
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    wait (digit_q.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic longint unsigned rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic longint unsigned rand_frac();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 24'hFFFFFF;
      default: return $urandom_range(0, 24'hFFFFFF);
    endcase
  endfunction

  function automatic longint unsigned rand_value();
    longint unsigned u;
    u = rand64();
    if ($urandom_range(0, 7) == 0) u = ~64'd0;
    if (cfg_mod != 0 && $urandom_range(0, 3) != 0) u = u % cfg_mod;
    return u;
  endfunction

  // Random traffic: mostly whole runs, some stray fractions and cut-off runs.
  task automatic random_phase(int n_items);
    int stop_at, kk, part;
    stop_at = items_sent + n_items;
    kk = cfg_k < 2 ? 2 : (cfg_k > KMAX ? KMAX : cfg_k);
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0: send_item(CMD_FRAC, 0, rand_frac());
        1: begin
          part = $urandom_range(0, kk - 1);
          send_item(CMD_VALUE, rand_value(), 0);
          repeat (part) send_item(CMD_FRAC, 0, rand_frac());
        end
        default: begin
          send_item(CMD_VALUE, rand_value(), 0);
          repeat (kk) send_item(CMD_FRAC, 0, rand_frac());
        end
      endcase
    end
  endtask

  // Receiver: random stalls, fast stretches and one long hold-off.
  bit pop_taken = 1;
  bit hold_done = 0;
  int pop_wait = 0;
  int pop_fast = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (pop_taken) begin
        pop_taken = 0;
        if (pop_fast > 0) begin
          pop_fast--;
          pop_wait = 0;
        end else begin
          pop_wait = $urandom_range(0, 5);
          if ($urandom_range(0, 15) == 0) pop_fast = $urandom_range(10, 40);
        end
      end
      if (!hold_done && digits_seen >= 40) begin
        hold_done = 1;
        pop_wait = 3000;
      end
      pop <= (pop_wait == 0);
      if (pop_wait > 0) pop_wait--;
    end
  end

  // Checker: each popped transaction against the oldest expected digit.
  always @(posedge clk) begin
    digit_exp_t e;
    if (!rst && pop && !empty) begin
      pop_taken = 1;
      digits_seen++;
      if (digit_q.size() == 0) begin
        $error("unexpected digit %0d at index %0d", digit, digit_index);
        fail_cnt++;
      end else begin
        e = digit_q.pop_front();
        if (digit !== e.dig) begin
          $error("digit: expected %0d, got %0d", e.dig, digit);
          fail_cnt++;
        end
        if (digit_index !== e.idx) begin
          $error("digit_index: expected %0d, got %0d", e.idx, digit_index);
          fail_cnt++;
        end
        if (last !== e.lst) begin
          $error("last: expected %0d, got %0d", e.lst, last);
          fail_cnt++;
        end
      end
    end
  end

  // Directed stimulus rows.
  typedef struct {
    bit              kind;
    longint unsigned u;
    longint unsigned r;
    bit              typed;
    longint          dig;
  } stim_row_t;

  stim_row_t dir_rows[] = '{
    '{CMD_FRAC,  64'd0, 64'h000123, 0, 0},   // no value pending: dropped
    '{CMD_VALUE, 64'd0, 64'd0, 0, 0},
    '{CMD_FRAC,  64'd0, 64'd1, 0, 0},
    '{CMD_FRAC,  64'd0, 64'hFFFFFF, 1, 0},   // zero value rounds to all-zero digits
    '{CMD_VALUE, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 0, 0},
    '{CMD_FRAC,  64'd0, 64'd0, 0, 0},
    '{CMD_FRAC,  64'd0, 64'd0, 0, 0},
    '{CMD_VALUE, 64'd3, 64'd0, 0, 0},
    '{CMD_VALUE, 64'd2, 64'd0, 0, 0},        // restart before any fraction
    '{CMD_FRAC,  64'd0, 64'h800000, 0, 0},
    '{CMD_FRAC,  64'd0, 64'h7FFFFF, 0, 0},
    '{CMD_VALUE, 64'd1, 64'd0, 0, 0},
    '{CMD_FRAC,  64'd0, 64'hFFFFFF, 0, 0},
    '{CMD_VALUE, 64'd0, 64'd0, 0, 0},        // restart mid-run
    '{CMD_FRAC,  64'd0, 64'd0, 0, 0},
    '{CMD_FRAC,  64'd0, 64'd0, 0, 0},
    '{CMD_FRAC,  64'd0, 64'h555555, 0, 0},   // run closed: dropped
    '{CMD_VALUE, 64'hAAAA_AAAA_AAAA_AAAA, 64'd0, 0, 0},
    '{CMD_FRAC,  64'd0, 64'hAAAAAA, 0, 0},
    '{CMD_FRAC,  64'd0, 64'h555555, 0, 0},
    '{CMD_VALUE, 64'h5555_5555_5555_5555, 64'd0, 0, 0},
    '{CMD_FRAC,  64'd0, 64'h000001, 0, 0},
    '{CMD_FRAC,  64'd0, 64'hFFFFFE, 0, 0}
  };

  // Main sequence: directed rows, then random phases over several settings.
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_config(64'hFFFF_FFFF_FFFF_FFFF, 2, 2);
    foreach (dir_rows[n])
      send_item(dir_rows[n].kind, dir_rows[n].u, dir_rows[n].r,
                dir_rows[n].typed, dir_rows[n].dig);
    settle();
    set_config(64'd4294967291, 2, 32);
    random_phase(60);
    settle();
    set_config(rand64(), 0, 0);
    random_phase(40);
    settle();
    set_config(64'hFFFF_FFFF_FFFF_FFFF, 21'h1FFFFF, 7'h7F);
    random_phase(30);
    settle();
    set_config(64'h8000_0000_0000_0000, 2, 8);
    random_phase(30);
    settle();
    set_config(64'd1, 16, 3);
    random_phase(25);
    settle();
    set_config(rand64(), $urandom_range(3, 1000), 4);
    random_phase(30);
    settle();
    set_config(64'd0, 1, 1);
    random_phase(15);
    settle();
    set_config(64'hFFFF_FFFF_FFFF_FFFF, 1 << 20, 3);
    random_phase(20);
    settle();
    $display("Sent %0d transactions over 9 settings; %0d runs completed, %0d digits checked.",
             items_sent, runs_done, digits_seen);
    if (fail_cnt == 0)
      $display("gadget_subgaussian_sampler_unit regression: pass");
    else
      $display("gadget_subgaussian_sampler_unit regression: fail");
    $finish;
  end

  // Watchdog.
  initial begin
    #10_000_000;
    $display("gadget_subgaussian_sampler_unit regression: fail");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/gss_pkg.sv
hw/rtl/gss_div.sv
hw/rtl/gss_front.sv
hw/rtl/gss_core.sv
hw/rtl/gadget_subgaussian_sampler_unit.sv
sim/tb_top.sv
